>>> design/arfdp_pkg.sv
// Shared types and constants of the audio ring FIFO drift packetizer.
package arfdp_pkg;

  localparam int RING_FRAMES_DEF    = 8192;
  localparam int NOMINAL_FRAMES_DEF = 48;

  localparam int SAMPLE_W     = 16;
  localparam int TARGET_W     = 14;
  localparam int MARGIN_W     = 13;
  localparam int FRAMES_W     = 7;   // holds a packet size up to 127
  localparam int PKT_FRAMES_W = 6;   // packet_frames as carried on the output
  localparam int OP_W         = 3;
  localparam int KIND_W       = 2;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 40;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 14'd1024;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 13'd128;

  // Configuration register indexes
  localparam logic REG_TARGET_FILL  = 1'b0;
  localparam logic REG_DRIFT_MARGIN = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_SILENCE   = 3'd2,
    OP_RESET     = 3'd3,
    OP_CLEAR_SEQ = 3'd4
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA      = 2'd0,
    KIND_REQUESTED = 2'd1,
    KIND_REBUFFER  = 2'd2,
    KIND_UNDERRUN  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] left;
  } frame_t;

  // Travels with each issued frame slot from the sequencer to the output queue
  typedef struct packed {
    logic                    silent;
    logic                    last;
    logic [PKT_FRAMES_W-1:0] frames;
    kind_t                   kind;
  } frame_tag_t;

endpackage

>>> design/audio_ring_fifo_drift_packetizer_unit.sv
// Top level of the audio ring FIFO drift packetizer.
//
// Input channel s_*: one item per transfer; s_tuser carries the opcode
// (push frame, pop packet, pop silence, reset ring, clear sequence) and
// s_tdata the stereo frame of a push. A push, reset or clear leaves the
// block ready, so pushes stream at one frame per cycle while no pop or
// silence is in progress. A pop spends a planning state on the captured
// fill, then issues one frame read per cycle from the single RAM read port
// while the output queue has room; the first frame reaches m_* through the
// registered RAM read and the queue, and the block takes its next item
// once the last read of the packet is issued; packets hold 47 to 49 frames.
// A silence request skips the planning state.
// Output channel m_*: one frame per transfer, m_tlast on the final frame of
// the packet, m_tuser the packet kind. A two-entry queue behind the RAM
// holds frames while the receiver stalls; reads stop until space returns.
// Configuration port cfg_*: always ready; index 0 target fill, 1 drift
// margin. Write it only while the block is idle.
// Reset: synchronous rst empties the ring, sets rebuffering, clears the
// packet parity and loads the register defaults. The frame store is not
// cleared and needs no clearing pass.
module audio_ring_fifo_drift_packetizer_unit #(
  parameter int RING_FRAMES    = arfdp_pkg::RING_FRAMES_DEF,
  parameter int NOMINAL_FRAMES = arfdp_pkg::NOMINAL_FRAMES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [arfdp_pkg::IN_DATA_W-1:0]    s_tdata,   // left_in, right_in
  input  logic [arfdp_pkg::OP_W-1:0]         s_tuser,   // opcode
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [arfdp_pkg::OUT_DATA_W-1:0]   m_tdata,   // left_out, right_out, packet_frames
  output logic [arfdp_pkg::KIND_W-1:0]       m_tuser,   // packet_kind
  output logic                               m_tlast,   // last_frame
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [arfdp_pkg::TARGET_W-1:0]     cfg_data
);
  import arfdp_pkg::*;

  localparam int ADDR_W = $clog2(RING_FRAMES);

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  frame_t            mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  frame_t            mem_rdata;
  logic              can_issue;
  logic              issue;
  frame_tag_t        issue_tag;

  assign cfg_ready = 1'b1;

  arfdp_ctrl #(
    .RING_FRAMES    (RING_FRAMES),
    .NOMINAL_FRAMES (NOMINAL_FRAMES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .can_issue (can_issue),
    .issue     (issue),
    .issue_tag (issue_tag)
  );

  arfdp_frame_ram #(
    .DEPTH (RING_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  arfdp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .issue_tag (issue_tag),
    .rd_data   (mem_rdata),
    .can_issue (can_issue),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

>>> design/arfdp_frame_ram.sv
// Frame store: one write port and one registered read port.
module arfdp_frame_ram #(
  parameter int DEPTH = arfdp_pkg::RING_FRAMES_DEF
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  arfdp_pkg::frame_t         wdata,
  input  logic                      re,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output arfdp_pkg::frame_t         rdata
);
  import arfdp_pkg::*;

  frame_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/arfdp_out_queue.sv
// Two-entry output queue that takes RAM read data and grants issue credit.
module arfdp_out_queue (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  issue,
  input  arfdp_pkg::frame_tag_t                 issue_tag,
  input  arfdp_pkg::frame_t                     rd_data,
  output logic                                  can_issue,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [arfdp_pkg::OUT_DATA_W-1:0]      m_tdata,   // left_out, right_out, packet_frames
  output logic [arfdp_pkg::KIND_W-1:0]          m_tuser,   // packet_kind
  output logic                                  m_tlast
);
  import arfdp_pkg::*;

  frame_t     data_q [2];
  frame_tag_t tag_q  [2];
  frame_tag_t fly_tag;
  logic       rd_pending;
  logic       head;
  logic [1:0] cnt;
  logic       take;
  logic [2:0] room_used;
  frame_t     fill_data;

  assign take      = m_tvalid && m_tready;
  assign room_used = 3'({1'b0, cnt}) + 3'(rd_pending) - 3'(take);
  assign can_issue = room_used < 3'd2;
  assign fill_data = fly_tag.silent ? '0 : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      head       <= 1'b0;
      cnt        <= '0;
    end else begin
      rd_pending <= issue;
      if (take) begin
        head <= ~head;
      end
      cnt <= 2'(room_used);
    end
    if (issue) begin
      fly_tag <= issue_tag;
    end
    // RAM data lands in the cycle after issue; slot follows the current tail
    if (rd_pending) begin
      data_q[head ^ cnt[0]] <= fill_data;
      tag_q[head ^ cnt[0]]  <= fly_tag;
    end
  end

  assign m_tvalid = cnt != 2'd0;
  assign m_tdata  = {2'b00, tag_q[head].frames, data_q[head].right, data_q[head].left};
  assign m_tuser  = tag_q[head].kind;
  assign m_tlast  = tag_q[head].last;

endmodule

>>> design/arfdp_ctrl.sv
// Ring counters, packet planning and the frame read sequencer.
module arfdp_ctrl #(
  parameter int RING_FRAMES    = arfdp_pkg::RING_FRAMES_DEF,
  parameter int NOMINAL_FRAMES = arfdp_pkg::NOMINAL_FRAMES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [arfdp_pkg::OP_W-1:0]          s_tuser,
  input  logic [arfdp_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                                cfg_valid,
  input  logic                                cfg_index,
  input  logic [arfdp_pkg::TARGET_W-1:0]      cfg_data,
  output logic                                mem_we,
  output logic [$clog2(RING_FRAMES)-1:0]      mem_waddr,
  output arfdp_pkg::frame_t                   mem_wdata,
  output logic                                mem_re,
  output logic [$clog2(RING_FRAMES)-1:0]      mem_raddr,
  input  logic                                can_issue,
  output logic                                issue,
  output arfdp_pkg::frame_tag_t               issue_tag
);
  import arfdp_pkg::*;

  localparam int ADDR_W = $clog2(RING_FRAMES);
  localparam int CNT_W  = $clog2(2 * RING_FRAMES);
  localparam int CMP_W  = ((CNT_W > TARGET_W + 1) ? CNT_W : TARGET_W + 1) + 1;
  localparam logic [CNT_W-1:0]    RING_C   = CNT_W'(RING_FRAMES);
  localparam logic [CNT_W-1:0]    CNT_MAX  = CNT_W'(2 * RING_FRAMES - 1);
  localparam logic [CNT_W:0]      TWO_RING = (CNT_W + 1)'(2 * RING_FRAMES);
  localparam logic [ADDR_W-1:0]   ADDR_MAX = ADDR_W'(RING_FRAMES - 1);
  localparam logic [FRAMES_W-1:0] NOM      = FRAMES_W'(NOMINAL_FRAMES);

  typedef enum logic [1:0] {ST_IDLE, ST_PLAN, ST_EMIT} state_t;

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? '0 : c + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] cnt_add(input logic [CNT_W-1:0] c,
                                               input logic [FRAMES_W-1:0] n);
    logic [CNT_W:0] s;
    s = {1'b0, c} + (CNT_W + 1)'(n);
    if (s >= TWO_RING) begin
      s = s - TWO_RING;
    end
    return s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] cnt_fill(input logic [CNT_W-1:0] w,
                                                input logic [CNT_W-1:0] r);
    logic [CNT_W:0] d;
    d = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      d = d + TWO_RING;
    end
    return d[CNT_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cnt_index(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] v;
    v = (c >= RING_C) ? c - RING_C : c;
    return v[ADDR_W-1:0];
  endfunction

  state_t               state;
  logic [CNT_W-1:0]     read_count;
  logic [CNT_W-1:0]     write_count;
  logic                 rebuffering;
  logic                 packet_parity;
  logic [TARGET_W-1:0]  target_fill;
  logic [MARGIN_W-1:0]  drift_margin;
  logic [CNT_W-1:0]     used_q;
  logic                 corrupt_q;
  logic [ADDR_W-1:0]    rd_addr;
  logic [FRAMES_W-1:0]  remaining;
  logic [FRAMES_W-1:0]  frames_q;
  kind_t                kind_q;
  logic                 silent_q;

  logic [CNT_W-1:0]     used_now;
  logic                 corrupt_now;
  logic                 accept;
  opcode_t              op;
  logic [CMP_W-1:0]     used_c;
  logic [CMP_W-1:0]     target_c;
  logic [CMP_W-1:0]     margin_c;
  logic                 rb_now;
  logic                 stay_rebuf;
  logic                 grow;
  logic                 shrink;
  logic [FRAMES_W-1:0]  size;
  logic                 underrun;

  assign used_now    = cnt_fill(write_count, read_count);
  assign corrupt_now = used_now > RING_C;
  assign s_tready    = state == ST_IDLE;
  assign accept      = s_tvalid && s_tready;
  assign op          = opcode_t'(s_tuser);

  // Pushes write in the accept cycle
  assign mem_we    = accept && (op == OP_PUSH);
  assign mem_waddr = cnt_index(write_count);
  assign mem_wdata = s_tdata;

  // Packet planning from the fill captured at accept
  always_comb begin
    used_c     = corrupt_q ? '0 : CMP_W'(used_q);
    target_c   = CMP_W'(target_fill);
    margin_c   = CMP_W'(drift_margin);
    rb_now     = rebuffering || corrupt_q;
    stay_rebuf = rb_now && (used_c < target_c);
    grow       = !packet_parity && (used_c > target_c + margin_c);
    shrink     = !packet_parity && !grow && (used_c + margin_c < target_c);
    size       = grow ? NOM + 1'b1 : (shrink ? NOM - 1'b1 : NOM);
    underrun   = used_c < CMP_W'(size);
  end

  assign issue            = (state == ST_EMIT) && can_issue;
  assign mem_re           = issue && !silent_q;
  assign mem_raddr        = rd_addr;
  assign issue_tag.silent = silent_q;
  assign issue_tag.last   = remaining == FRAMES_W'(1);
  assign issue_tag.frames = frames_q[PKT_FRAMES_W-1:0];
  assign issue_tag.kind   = kind_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      read_count    <= '0;
      write_count   <= '0;
      rebuffering   <= 1'b1;
      packet_parity <= 1'b0;
      target_fill   <= TARGET_RESET;
      drift_margin  <= MARGIN_RESET;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_TARGET_FILL) begin
          target_fill <= cfg_data;
        end else begin
          drift_margin <= cfg_data[MARGIN_W-1:0];
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (op)
              OP_PUSH: begin
                if (corrupt_now) begin
                  read_count <= write_count;
                end else if (used_now == RING_C) begin
                  // drop the oldest frame
                  read_count <= cnt_inc(read_count);
                end
                write_count <= cnt_inc(write_count);
              end
              OP_POP: begin
                used_q    <= used_now;
                corrupt_q <= corrupt_now;
                state     <= ST_PLAN;
              end
              OP_SILENCE: begin
                silent_q  <= 1'b1;
                kind_q    <= KIND_REQUESTED;
                frames_q  <= NOM;
                remaining <= NOM;
                state     <= ST_EMIT;
              end
              OP_RESET: begin
                read_count  <= '0;
                write_count <= '0;
                rebuffering <= 1'b1;
              end
              OP_CLEAR_SEQ: begin
                packet_parity <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_PLAN: begin
          state <= ST_EMIT;
          if (stay_rebuf) begin
            kind_q      <= KIND_REBUFFER;
            silent_q    <= 1'b1;
            remaining   <= NOM;
            frames_q    <= NOM;
            rebuffering <= 1'b1;
            if (corrupt_q) begin
              read_count <= write_count;
            end
          end else begin
            packet_parity <= ~packet_parity;
            if (underrun) begin
              kind_q      <= KIND_UNDERRUN;
              silent_q    <= 1'b1;
              remaining   <= NOM;
              frames_q    <= NOM;
              rebuffering <= 1'b1;
              if (corrupt_q) begin
                read_count <= write_count;
              end
            end else begin
              kind_q      <= KIND_DATA;
              silent_q    <= 1'b0;
              rebuffering <= 1'b0;
              remaining   <= size;
              frames_q    <= size;
              rd_addr     <= cnt_index(read_count);
              read_count  <= cnt_add(read_count, size);
            end
          end
        end
        ST_EMIT: begin
          if (can_issue) begin
            remaining <= remaining - 1'b1;
            rd_addr   <= (rd_addr == ADDR_MAX) ? '0 : rd_addr + 1'b1;
            if (remaining == FRAMES_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/arfdp_checker.sv
// Port-level checks of the packetizer output, bound to the top level.
module arfdp_checker #(
  parameter int NOMINAL_FRAMES = arfdp_pkg::NOMINAL_FRAMES_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [arfdp_pkg::OUT_DATA_W-1:0]   m_tdata,
  input logic [arfdp_pkg::KIND_W-1:0]       m_tuser,
  input logic                               m_tlast
);
  import arfdp_pkg::*;

  localparam logic [PKT_FRAMES_W-1:0] NOM6 = PKT_FRAMES_W'(NOMINAL_FRAMES);
  localparam logic [PKT_FRAMES_W-1:0] LO6  = PKT_FRAMES_W'(NOMINAL_FRAMES - 1);
  localparam logic [PKT_FRAMES_W-1:0] HI6  = PKT_FRAMES_W'(NOMINAL_FRAMES + 1);
  localparam logic [KIND_W-1:0]       DATA = KIND_W'(KIND_DATA);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output frame changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != DATA |-> m_tdata[31:0] == 32'd0)
    else $error("silent frame carries samples");

  a_silent_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != DATA |-> m_tdata[37:32] == NOM6)
    else $error("silent packet size is not nominal");

  a_size_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[37:32] == LO6 || m_tdata[37:32] == NOM6
                 || m_tdata[37:32] == HI6)
    else $error("packet size outside nominal plus or minus one");

endmodule

bind audio_ring_fifo_drift_packetizer_unit arfdp_checker #(
  .NOMINAL_FRAMES (NOMINAL_FRAMES)
) u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
